// File: sv/gfv_pkg.sv
`default_nettype none
package gfv_pkg;

  localparam int POS_BITS       = 27;
  localparam int CNT_OUT_BITS   = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [POS_BITS-1:0] POS_MAX      = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] HEADER_BYTES = POS_BITS'(16);
  localparam logic [POS_BITS-1:0] MIN_LENGTH   = POS_BITS'(20);
  localparam logic [POS_BITS-1:0] EDITION_POS  = POS_BITS'(7);
  localparam logic [POS_BITS-1:0] LEN_FIRST    = POS_BITS'(8);
  localparam logic [POS_BITS-1:0] MAGIC_BYTES  = POS_BITS'(4);
  localparam logic [7:0]          EDITION      = 8'd2;
  localparam logic [31:0]         END_MARK     = 32'h3737_3737;
  localparam logic [15:0]         MAX_MSG_RST  = 16'hFFFF;

  localparam logic [7:0] MAGIC [4] = '{8'h47, 8'h52, 8'h49, 8'h42};

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_NOT_GRIB2  = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_NO_END     = 3'd4;
  localparam logic [2:0] ST_TOO_MANY   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       payload_last;
  } in_item_t;

  typedef struct packed {
    logic                    message_end;
    logic                    payload_end;
    logic [2:0]              status;
    logic [CNT_OUT_BITS-1:0] msg_total;
    logic [POS_BITS-1:0]     message_length;
  } out_item_t;

  // per-message tracking state; the declared length keeps its low bits
  // plus a flag for any set bit above them
  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] len_lo;
    logic                len_hi;
    logic                hdr_bad;
    logic [31:0]         tail;
    logic                discarding;
  } trk_state_t;

endpackage
`default_nettype wire

// File: sv/gfv_tracker.sv
`default_nettype none
module gfv_tracker
  import gfv_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc,
  input  wire in_item_t  item,
  input  wire logic [15:0] msg_limit,
  output logic           res_valid,
  output out_item_t      res
);

  localparam int CMP_W = (COUNT_BITS > CNT_OUT_BITS) ? COUNT_BITS : CNT_OUT_BITS;

  trk_state_t            st_r, st_nxt;
  logic [COUNT_BITS-1:0] seen_r, seen_nxt;

  logic [POS_BITS:0]     np;
  logic [POS_BITS-1:0]   p;
  logic [7:0]            b;
  logic                  last;
  logic                  hb;
  logic [POS_BITS-1:0]   len_lo;
  logic                  len_hi;
  logic [31:0]           tail;
  logic                  too_many;
  logic                  fail;
  logic [2:0]            fail_st;
  logic                  close_ok;
  logic [CMP_W-1:0]      seen_ext;
  logic [CMP_W-1:0]      seen_inc_ext;

  always_comb begin
    p      = st_r.pos;
    b      = item.data_byte;
    last   = item.payload_last;
    np     = {1'b0, p} + (POS_BITS+1)'(1);
    hb     = st_r.hdr_bad;
    len_lo = st_r.len_lo;
    len_hi = st_r.len_hi;
    if (p < MAGIC_BYTES && b != MAGIC[p[1:0]]) hb = 1'b1;
    if (p == EDITION_POS && b != EDITION) hb = 1'b1;
    if (p >= LEN_FIRST && p < HEADER_BYTES) begin
      len_hi = len_hi | (|len_lo[POS_BITS-1:POS_BITS-8]);
      len_lo = {len_lo[POS_BITS-9:0], b};
    end
    tail = {st_r.tail[23:0], b};

    seen_ext     = CMP_W'(seen_r);
    seen_inc_ext = CMP_W'(seen_r + COUNT_BITS'(1));
    too_many     = (seen_ext >= CMP_W'(msg_limit)) || (&seen_r);

    fail     = 1'b0;
    fail_st  = ST_OK;
    close_ok = 1'b0;
    if (p == HEADER_BYTES - POS_BITS'(1) && hb) begin
      fail = 1'b1; fail_st = ST_NOT_GRIB2;
    end else if (p == HEADER_BYTES - POS_BITS'(1) && !len_hi && len_lo < MIN_LENGTH) begin
      fail = 1'b1; fail_st = ST_BAD_LENGTH;
    end else if (np >= {1'b0, MIN_LENGTH} && !len_hi && np == {1'b0, len_lo}) begin
      if (tail != END_MARK) begin
        fail = 1'b1; fail_st = ST_NO_END;
      end else if (too_many) begin
        fail = 1'b1; fail_st = ST_TOO_MANY;
      end else begin
        close_ok = 1'b1;
      end
    end else if (last) begin
      fail    = 1'b1;
      fail_st = (np < {1'b0, HEADER_BYTES}) ? ST_SHORT : ST_BAD_LENGTH;
    end

    st_nxt         = st_r;
    seen_nxt       = seen_r;
    res_valid      = 1'b0;
    res            = '0;
    res.payload_end = last;

    if (st_r.discarding) begin
      // dropping until the payload closes, no result
      if (last) begin
        st_nxt   = '0;
        seen_nxt = '0;
      end
    end else begin
      st_nxt.pos     = np[POS_BITS] ? POS_MAX : np[POS_BITS-1:0];
      st_nxt.len_lo  = len_lo;
      st_nxt.len_hi  = len_hi;
      st_nxt.hdr_bad = hb;
      st_nxt.tail    = tail;
      if (fail) begin
        res_valid         = 1'b1;
        res.status        = fail_st;
        res.msg_total     = seen_ext[CNT_OUT_BITS-1:0];
        st_nxt            = '0;
        st_nxt.discarding = !last;
        if (last) seen_nxt = '0;
      end else if (close_ok) begin
        res_valid          = 1'b1;
        res.message_end    = 1'b1;
        res.status         = ST_OK;
        res.msg_total      = seen_inc_ext[CNT_OUT_BITS-1:0];
        res.message_length = len_lo;
        st_nxt             = '0;
        seen_nxt           = last ? '0 : seen_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      seen_r <= '0;
    end else if (acc) begin
      st_r   <= st_nxt;
      seen_r <= seen_nxt;
    end
  end

  // after an error the message state is cleared and stays so while dropping
  a_discard_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.discarding |-> (st_r.pos == '0 && !st_r.hdr_bad))
    else $error("message state not clear while dropping");

  // a header mismatch is reported by the 16th byte at the latest
  a_hdr_window: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hdr_bad |-> (st_r.pos != '0 && st_r.pos < HEADER_BYTES))
    else $error("header error held past the header");

  a_close_len: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && res.message_end) |->
      (res.status == ST_OK && res.message_length >= MIN_LENGTH))
    else $error("closed message with bad status or length");

  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && !res.message_end) |->
      (res.message_length == '0 && res.status != ST_OK))
    else $error("error result carries a length");

endmodule
`default_nettype wire

// File: sv/gfv_out_stage.sv
`default_nettype none
module gfv_out_stage
  import gfv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_item_t res,
  output logic           space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;

  // free when empty or when the held result leaves this cycle
  assign space     = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

// File: sv/grib2_frame_validator_core.sv
// output: a result is in the output register in the cycle after its byte's transfer
// throughput: one byte per cycle; the per-byte state update in the tracker sets it,
//   and the single output register stalls input only while a result waits
// reset: synchronous, active low; clears all message and payload state, empties
//   the output register and sets the message limit to 65535
`default_nettype none
module grib2_frame_validator_core
  import gfv_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic        cfg_wr;
  logic [15:0] max_msg_r;
  logic        acc;
  logic        res_valid;
  out_item_t   res;
  logic        space;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r <= MAX_MSG_RST;
    end else if (cfg_wr) begin
      max_msg_r <= cfg_data;
    end
  end

  assign in_ready = space;
  assign acc      = in_valid && in_ready;

  gfv_tracker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .item        (in_data),
    .msg_limit   (max_msg_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  gfv_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc && res_valid),
    .res      (res),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import gfv_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS_DEF) - 1;

  typedef enum int {
    MK_GOOD, MK_BAD_MAGIC, MK_BAD_EDITION, MK_SHORT_LEN, MK_HUGE_LEN, MK_BAD_END,
    MK_TRUNCATED
  } msg_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  grib2_frame_validator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // framing state as the checker should hold it
  longint unsigned fv_pos = 0;
  logic [63:0]     fv_len = '0;
  bit              fv_hdr_bad = 1'b0;
  logic [31:0]     fv_tail = '0;
  int unsigned     fv_count = 0;
  bit              fv_drop = 1'b0;
  logic [15:0]     fv_max = MAX_MSG_RST;

  in_item_t    bytes_pending[$];
  out_item_t   results_due[$];
  logic [7:0]  frame_buf[$];
  int          bytes_queued = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          in_taken = 1'b0;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 80;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  function automatic void clear_message();
    fv_pos = 0;
    fv_len = '0;
    fv_hdr_bad = 1'b0;
    fv_tail = '0;
  endfunction

  function automatic void clear_payload();
    clear_message();
    fv_count = 0;
    fv_drop = 1'b0;
  endfunction

  function automatic bit frame_fault(input bit last, input logic [2:0] st,
                                     output out_item_t res);
    res = '0;
    res.payload_end = last;
    res.status = st;
    res.msg_total = fv_count[15:0];
    if (last) begin
      clear_payload();
    end else begin
      clear_message();
      fv_drop = 1'b1;
    end
    return 1'b1;
  endfunction

  // returns 1 when this byte produces a result
  function automatic bit predict_frame(input in_item_t it, output out_item_t res);
    logic [7:0]      b;
    bit              last;
    longint unsigned p;
    longint unsigned np;
    b = it.data_byte;
    last = it.payload_last;
    p = fv_pos;
    np = p + 1;
    res = '0;
    if (fv_drop) begin
      if (last) clear_payload();
      return 1'b0;
    end
    if (p < MAGIC_BYTES && b != MAGIC[int'(p)]) fv_hdr_bad = 1'b1;
    if (p == EDITION_POS && b != EDITION) fv_hdr_bad = 1'b1;
    if (p >= LEN_FIRST && p < HEADER_BYTES) fv_len = {fv_len[55:0], b};
    fv_tail = {fv_tail[23:0], b};
    fv_pos = (np > POS_MAX) ? POS_MAX : np;
    if (p == HEADER_BYTES - 1) begin
      if (fv_hdr_bad) return frame_fault(last, ST_NOT_GRIB2, res);
      if (fv_len < MIN_LENGTH) return frame_fault(last, ST_BAD_LENGTH, res);
    end
    if (np >= MIN_LENGTH && np == fv_len && fv_len <= POS_MAX) begin
      if (fv_tail != END_MARK) return frame_fault(last, ST_NO_END, res);
      if (fv_count >= fv_max || fv_count >= COUNT_LIMIT)
        return frame_fault(last, ST_TOO_MANY, res);
      fv_count++;
      res.message_end = 1'b1;
      res.payload_end = last;
      res.status = ST_OK;
      res.msg_total = fv_count[15:0];
      res.message_length = fv_len[POS_BITS-1:0];
      if (last) clear_payload();
      else clear_message();
      return 1'b1;
    end
    if (last)
      return frame_fault(1'b1, (np < HEADER_BYTES) ? ST_SHORT : ST_BAD_LENGTH, res);
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // driver: next byte goes out once the previous one is transferred
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (bytes_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= bytes_pending.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t pred;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, status", out_data.status, 0);
        end else begin
          want = results_due.pop_front();
          if (out_data.message_end != want.message_end)
            report_mismatch("message_end", out_data.message_end, want.message_end);
          if (out_data.payload_end != want.payload_end)
            report_mismatch("payload_end", out_data.payload_end, want.payload_end);
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.msg_total != want.msg_total)
            report_mismatch("msg_total", out_data.msg_total, want.msg_total);
          if (out_data.message_length != want.message_length)
            report_mismatch("message_length", out_data.message_length,
                            want.message_length);
        end
      end
      if (in_taken) begin
        if (predict_frame(in_data, pred)) results_due.push_back(pred);
      end
      if (in_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_msg_limit(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fv_max = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (bytes_pending.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    // a trailing byte may give no result but still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic push_payload();
    in_item_t it;
    for (int i = 0; i < frame_buf.size(); i++) begin
      it.data_byte = frame_buf[i];
      it.payload_last = (i == frame_buf.size() - 1);
      bytes_pending.push_back(it);
      bytes_queued++;
    end
    frame_buf.delete();
  endtask

  task automatic append_message(input msg_kind_e kind, input int len);
    logic [63:0] decl;
    logic [7:0]  b;
    int          base;
    int          cut;
    decl = 64'(len);
    base = frame_buf.size();
    if (kind == MK_SHORT_LEN) decl = 64'($urandom_range(19, 0));
    if (kind == MK_HUGE_LEN) decl = {$urandom, $urandom} | (64'd1 << $urandom_range(63, 27));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255, 0));
      if (i < 4) b = MAGIC[i];
      else if (i == 7) b = EDITION;
      else if (i >= 8 && i < 16) b = decl[8*(15-i) +: 8];
      else if (i >= len - 4) b = END_MARK[7:0];
      frame_buf.push_back(b);
    end
    case (kind)
      MK_BAD_MAGIC: begin
        frame_buf[base + $urandom_range(3, 0)] ^= 8'($urandom_range(255, 1));
      end
      MK_BAD_EDITION: begin
        frame_buf[base + 7] ^= 8'($urandom_range(255, 1));
      end
      MK_BAD_END: begin
        frame_buf[base + len - $urandom_range(4, 1)] ^= 8'($urandom_range(255, 1));
      end
      MK_TRUNCATED: begin
        cut = $urandom_range(len - 1, 1);
        repeat (cut) void'(frame_buf.pop_back());
      end
      default: ;
    endcase
  endtask

  task automatic append_noise(input int n);
    repeat (n) frame_buf.push_back(8'($urandom_range(255, 0)));
  endtask

  task automatic random_payload();
    int        nmsg;
    int        r;
    int        len;
    msg_kind_e kind;
    if ($urandom_range(19, 0) == 0) begin
      append_noise($urandom_range(40, 1));
    end else begin
      nmsg = $urandom_range(4, 1);
      for (int m = 0; m < nmsg; m++) begin
        r = $urandom_range(99, 0);
        if (r < 70) kind = MK_GOOD;
        else if (r < 75) kind = MK_BAD_MAGIC;
        else if (r < 80) kind = MK_BAD_EDITION;
        else if (r < 84) kind = MK_SHORT_LEN;
        else if (r < 88) kind = MK_HUGE_LEN;
        else if (r < 94) kind = MK_BAD_END;
        else kind = MK_TRUNCATED;
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 20);
        append_message(kind, len);
        // these run to the end of the payload
        if (kind == MK_HUGE_LEN || kind == MK_TRUNCATED) break;
      end
      if ($urandom_range(9, 0) == 0) append_noise($urandom_range(15, 1));
    end
    push_payload();
  endtask

  task automatic random_phase(input int nbytes);
    int stop_at;
    stop_at = bytes_queued + nbytes;
    while (bytes_queued < stop_at) random_payload();
  endtask

  initial begin
    out_item_t left_over;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_msg_limit(16'hFFFF);
    // directed payloads
    frame_buf.push_back(MAGIC[0]);
    push_payload();
    append_message(MK_GOOD, 20);
    push_payload();
    append_message(MK_GOOD, 20);
    append_message(MK_GOOD, 24);
    append_message(MK_GOOD, 33);
    push_payload();
    append_message(MK_BAD_MAGIC, 20);
    push_payload();
    append_message(MK_BAD_MAGIC, 20);
    while (frame_buf.size() > 16) void'(frame_buf.pop_back());
    push_payload();
    append_message(MK_BAD_EDITION, 22);
    append_message(MK_GOOD, 20);
    push_payload();
    append_message(MK_SHORT_LEN, 20);
    push_payload();
    append_message(MK_HUGE_LEN, 24);
    push_payload();
    append_message(MK_TRUNCATED, 30);
    push_payload();
    append_message(MK_BAD_END, 21);
    push_payload();
    append_message(MK_GOOD, 20);
    append_noise(5);
    push_payload();
    append_message(MK_BAD_MAGIC, 10);
    push_payload();
    drain();

    write_msg_limit(16'd1);
    hold_req = 1'b1;
    random_phase(200);
    drain();

    send_idle_pct = 80;
    recv_idle_pct = 30;
    write_msg_limit(16'd2);
    random_phase(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_msg_limit(16'($urandom_range(6, 3)));
    random_phase(150);
    drain();

    write_msg_limit(16'($urandom_range(65535, 1)));
    random_phase(150);
    drain();

    while (results_due.size() != 0) begin
      left_over = results_due.pop_front();
      report_mismatch("missing result, status", 0, left_over.status);
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/gfv_pkg.sv
sv/gfv_tracker.sv
sv/gfv_out_stage.sv
sv/grib2_frame_validator_core.sv
dv/testbench.sv
